// File: sv/csma_pkg.sv
// shared types and constants of the csma/cd station transmit control unit
package csma_pkg;

    // input item fields
    typedef struct packed {
        logic        packet_arrives;
        logic [7:0]  others_driving;
        logic [9:0]  backoff_random;
        logic [15:0] persist_random;
    } in_item_t;

    // result item fields
    typedef struct packed {
        logic [2:0]  station_state;
        logic        drives_medium;
        logic        packet_sent;
        logic [31:0] packet_delay;
        logic        packet_abandoned;
        logic        arrival_lost;
        logic [6:0]  queue_level;
        logic [31:0] sent_total;
        logic [47:0] delay_total;
    } out_item_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_PROB  = 2'd1,
        CFG_SPEED = 2'd2,
        CFG_LEN   = 2'd3
    } cfg_idx_t;

    // divider operand selection
    typedef enum logic [1:0] {
        DIV_PACKET = 2'd0,
        DIV_SENSE  = 2'd1,
        DIV_WAIT   = 2'd2
    } div_sel_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     pkt_load;
        logic     sense_load;
        logic     update;
    } ctl_cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic stale;
        logic div_done;
    } ctl_sts_t;

    localparam int CFG_W  = 17;
    localparam int DIV_W  = 19;
    localparam int DVS_W  = 6;

    // persistence modes
    localparam logic [1:0] MODE_NONPERSIST = 2'd1;
    localparam logic [1:0] MODE_PPERSIST   = 2'd2;

    // timing constants in bit times
    localparam int SENSE_BITS  = 96;
    localparam int BYTE_SHIFT  = 3;
    localparam int SLOT_SHIFT  = 9;
    localparam logic [9:0] BACKOFF_MOD = 10'd1023;

    // reset values of the registers and of the derived tick counts
    localparam logic [1:0]  MODE_RST  = 2'd0;
    localparam logic [16:0] PROB_RST  = 17'd32768;
    localparam logic [5:0]  SPEED_RST = 6'd1;
    localparam logic [12:0] LEN_RST   = 13'd1000;
    localparam logic [15:0] PKT_TICKS_RST   = 16'd8000;
    localparam logic [6:0]  SENSE_TICKS_RST = 7'd96;

endpackage

// File: sv/csma_div.sv
// iterative restoring divider, one quotient bit per cycle
module csma_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [csma_pkg::DIV_W-1:0]    dividend,
    input  logic [csma_pkg::DVS_W-1:0]    divisor,
    output logic                          done,
    output logic [csma_pkg::DIV_W-1:0]    quotient
);

    localparam int DW = csma_pkg::DIV_W;
    localparam int VW = csma_pkg::DVS_W;
    localparam int CW = $clog2(DW);

    logic [DW-1:0] acc_reg, acc_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   shifted;
    logic          fits;

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg, acc_reg[DW-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? VW'(shifted - {1'b0, dvs_reg}) : shifted[VW-1:0];
        acc_next = {acc_reg[DW-2:0], fits};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

// File: sv/csma_dp.sv
// datapath: registers, arrival queue, station state and timing counters
module csma_dp #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int MAX_ATTEMPTS = 10,
    parameter int TICK_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [csma_pkg::CFG_W-1:0]    cfg_wdata,
    input  csma_pkg::in_item_t            in_data,
    input  csma_pkg::ctl_cmd_t            cmd,
    output csma_pkg::ctl_sts_t            sts,
    output csma_pkg::out_item_t           out_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = TICK_WIDTH;
    localparam int DW = csma_pkg::DIV_W;

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_SENSING      = 3'd1,
        ST_TRANSMITTING = 3'd2,
        ST_JAMMING      = 3'd3,
        ST_WAITING      = 3'd4,
        ST_DEFERRED     = 3'd5
    } station_t;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [16:0] prob_reg;
    logic [5:0]  speed_reg;
    logic [12:0] len_reg;
    logic        stale_reg;
    logic [15:0] pticks_reg;
    logic [6:0]  senset_reg;

    // queue and station
    logic [TW-1:0] stamps [QUEUE_DEPTH];
    logic [PW-1:0] head_reg, tail_reg;
    logic [NW-1:0] count_reg;
    logic [TW-1:0] tick_reg, stamp_reg;
    station_t      st_reg, st_next;
    logic [3:0]    att_reg, att_next;
    logic [15:0]   svc_reg, svc_next;
    logic [6:0]    sense_reg, sense_next;
    logic [5:0]    jam_reg, jam_next;
    logic [18:0]   wait_reg, wait_next;
    logic [31:0]   sent_reg;
    logic [47:0]   dsum_reg;
    logic          lost_reg;
    logic [31:0]   delay_reg;
    csma_pkg::in_item_t  item_reg;
    csma_pkg::out_item_t out_reg;

    // divider
    logic [5:0]    speed_eff;
    logic [9:0]    brnd_mod;
    logic [DW-1:0] dividend;
    logic          div_done;
    logic [DW-1:0] quo;

    assign speed_eff = (speed_reg == '0) ? 6'd1 : speed_reg;
    assign brnd_mod  = (item_reg.backoff_random == csma_pkg::BACKOFF_MOD)
                       ? 10'd0 : item_reg.backoff_random;

    always_comb
    begin
        unique case (cmd.div_sel)
            csma_pkg::DIV_PACKET: dividend = DW'(len_reg) << csma_pkg::BYTE_SHIFT;
            csma_pkg::DIV_SENSE:  dividend = DW'(csma_pkg::SENSE_BITS);
            csma_pkg::DIV_WAIT:   dividend = DW'(brnd_mod) << csma_pkg::SLOT_SHIFT;
            default:              dividend = '0;
        endcase
    end

    csma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (speed_eff),
        .done     (div_done),
        .quotient (quo)
    );

    assign sts.stale    = stale_reg;
    assign sts.div_done = div_done;

    // configuration writes and derived tick counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= csma_pkg::MODE_RST;
            prob_reg   <= csma_pkg::PROB_RST;
            speed_reg  <= csma_pkg::SPEED_RST;
            len_reg    <= csma_pkg::LEN_RST;
            stale_reg  <= 1'b0;
            pticks_reg <= csma_pkg::PKT_TICKS_RST;
            senset_reg <= csma_pkg::SENSE_TICKS_RST;
        end
        else
        begin
            if (cmd.pkt_load)
                pticks_reg <= quo[15:0];
            if (cmd.sense_load)
            begin
                senset_reg <= quo[6:0];
                stale_reg  <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (csma_pkg::cfg_idx_t'(cfg_index))
                    csma_pkg::CFG_MODE:  mode_reg <= cfg_wdata[1:0];
                    csma_pkg::CFG_PROB:  prob_reg <= cfg_wdata[16:0];
                    csma_pkg::CFG_SPEED:
                    begin
                        speed_reg <= cfg_wdata[5:0];
                        stale_reg <= 1'b1;
                    end
                    csma_pkg::CFG_LEN:
                    begin
                        len_reg   <= cfg_wdata[12:0];
                        stale_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // arrival stamp memory, head read registered
    logic [TW-1:0] tick_inc;
    logic          do_push;
    assign tick_inc = tick_reg + 1'b1;
    assign do_push  = cmd.accept && in_data.packet_arrives && (count_reg < NW'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (do_push)
            stamps[tail_reg] <= tick_inc;
        if (cmd.accept)
            stamp_reg <= (count_reg == '0) ? tick_inc : stamps[head_reg];
    end

    // delay of the head packet
    logic [TW-1:0] diff;
    logic [TW:0]   diff1;
    logic [63:0]   diff64;
    assign diff   = tick_reg - stamp_reg;
    assign diff1  = {1'b0, diff} + 1'b1;
    assign diff64 = 64'(diff1);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            delay_reg <= (diff64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff64[31:0];
    end

    // one tick of the station controller
    logic          pop, sent, aband, noi;
    logic [31:0]   delay_v;
    logic [NW-1:0] cnt_after;
    logic          free_tx, free_defer, do_wait, do_backoff;
    logic [5:0]    jamt;
    logic          at_limit;

    assign jamt     = senset_reg[6:1];
    assign at_limit = att_reg >= 4'(MAX_ATTEMPTS);

    always_comb
    begin
        st_next    = st_reg;
        att_next   = att_reg;
        svc_next   = svc_reg;
        sense_next = sense_reg;
        jam_next   = jam_reg;
        wait_next  = wait_reg;
        pop        = 1'b0;
        sent       = 1'b0;
        aband      = 1'b0;
        noi        = 1'b0;
        delay_v    = '0;
        free_tx    = 1'b0;
        free_defer = 1'b0;
        do_wait    = 1'b0;
        do_backoff = 1'b0;

        unique case (st_reg)
            ST_IDLE:
                if (count_reg != '0)
                    noi = 1'b1;
            ST_SENSING:
                if (item_reg.others_driving == '0)
                begin
                    if (sense_reg <= 7'd1)
                    begin
                        sense_next = '0;
                        free_tx    = 1'b1;
                    end
                    else
                        sense_next = sense_reg - 1'b1;
                end
                else
                begin
                    sense_next = senset_reg;
                    if (mode_reg == csma_pkg::MODE_NONPERSIST ||
                        mode_reg == csma_pkg::MODE_PPERSIST)
                        do_wait = 1'b1;
                end
            ST_TRANSMITTING:
                if (svc_reg <= 16'd1)
                begin
                    svc_next = '0;
                    if (count_reg != '0)
                        delay_v = delay_reg;
                    pop      = 1'b1;
                    att_next = '0;
                    sent     = 1'b1;
                    noi      = 1'b1;
                end
                else
                begin
                    svc_next = svc_reg - 1'b1;
                    if (item_reg.others_driving != '0)
                    begin
                        st_next  = ST_JAMMING;
                        jam_next = jamt;
                    end
                end
            ST_JAMMING:
                if (jam_reg <= 6'd1)
                begin
                    jam_next   = jamt;
                    do_backoff = 1'b1;
                end
                else
                    jam_next = jam_reg - 1'b1;
            ST_WAITING:
                if (wait_reg <= 19'd1)
                begin
                    wait_next = '0;
                    noi       = 1'b1;
                end
                else
                    wait_next = wait_reg - 1'b1;
            ST_DEFERRED:
                if (item_reg.others_driving == '0)
                    free_tx = 1'b1;
                else
                    do_backoff = 1'b1;
            default:
                noi = 1'b1;
        endcase

        // channel found free: p-persistent may defer
        if (free_tx)
        begin
            if (mode_reg == csma_pkg::MODE_PPERSIST &&
                !({1'b0, item_reg.persist_random} < prob_reg))
            begin
                st_next    = ST_DEFERRED;
                sense_next = senset_reg;
            end
            else
            begin
                st_next    = ST_TRANSMITTING;
                svc_next   = pticks_reg;
                sense_next = senset_reg;
            end
        end

        // backoff or give up on the head packet
        if (do_backoff)
        begin
            if (at_limit)
            begin
                pop      = 1'b1;
                att_next = '0;
                aband    = 1'b1;
                noi      = 1'b1;
            end
            else
            begin
                att_next = att_reg + 1'b1;
                do_wait  = 1'b1;
            end
        end

        if (do_wait)
        begin
            wait_next = quo;
            st_next   = ST_WAITING;
        end

        cnt_after = (pop && count_reg != '0) ? count_reg - 1'b1 : count_reg;
        if (noi)
        begin
            if (cnt_after == '0)
                st_next = ST_IDLE;
            else
            begin
                st_next    = ST_SENSING;
                sense_next = senset_reg;
            end
        end
    end

    // queue pointers, tick counter and station registers
    logic [PW-1:0] head_inc, tail_inc;
    assign head_inc = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            tick_reg  <= '0;
            st_reg    <= ST_IDLE;
            att_reg   <= '0;
            svc_reg   <= csma_pkg::PKT_TICKS_RST;
            sense_reg <= csma_pkg::SENSE_TICKS_RST;
            jam_reg   <= csma_pkg::SENSE_TICKS_RST[6:1];
            wait_reg  <= '0;
            sent_reg  <= '0;
            dsum_reg  <= '0;
            lost_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            tick_reg <= tick_inc;
            lost_reg <= in_data.packet_arrives && !do_push;
            if (do_push)
            begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + 1'b1;
            end
        end
        else if (cmd.update)
        begin
            st_reg    <= st_next;
            att_reg   <= att_next;
            svc_reg   <= svc_next;
            sense_reg <= sense_next;
            jam_reg   <= jam_next;
            wait_reg  <= wait_next;
            count_reg <= cnt_after;
            if (pop && count_reg != '0)
                head_reg <= head_inc;
            if (sent)
            begin
                sent_reg <= sent_reg + 1'b1;
                dsum_reg <= dsum_reg + 48'(delay_v);
            end
        end
    end

    // input item latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_data;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_reg.station_state    <= st_next;
            out_reg.drives_medium    <= (st_next == ST_TRANSMITTING) ||
                                        (st_next == ST_JAMMING);
            out_reg.packet_sent      <= sent;
            out_reg.packet_delay     <= delay_v;
            out_reg.packet_abandoned <= aband;
            out_reg.arrival_lost     <= lost_reg;
            out_reg.queue_level      <= 7'(cnt_after);
            out_reg.sent_total       <= sent ? sent_reg + 1'b1 : sent_reg;
            out_reg.delay_total      <= sent ? dsum_reg + 48'(delay_v) : dsum_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// File: sv/csma_ctrl.sv
// sequencer: item handshake, divider runs and datapath update
module csma_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  csma_pkg::ctl_sts_t  sts,
    output csma_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_PKT_GO,
        C_PKT_RUN,
        C_SNS_GO,
        C_SNS_RUN,
        C_START,
        C_DIV,
        C_UPD
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_update;

    assign can_update = !out_valid_reg || out_ready;

    // commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = csma_pkg::DIV_WAIT;
        in_ready   = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready = !sts.stale;
                if (sts.stale)
                    state_next = C_PKT_GO;
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = C_START;
                end
            end
            C_PKT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = csma_pkg::DIV_PACKET;
                state_next    = C_PKT_RUN;
            end
            C_PKT_RUN:
                if (sts.div_done)
                begin
                    cmd.pkt_load = 1'b1;
                    state_next   = C_SNS_GO;
                end
            C_SNS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = csma_pkg::DIV_SENSE;
                state_next    = C_SNS_RUN;
            end
            C_SNS_RUN:
                if (sts.div_done)
                begin
                    cmd.sense_load = 1'b1;
                    state_next     = C_IDLE;
                end
            C_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = C_DIV;
            end
            C_DIV:
                if (sts.div_done)
                    state_next = C_UPD;
            C_UPD:
                if (can_update)
                begin
                    cmd.update = 1'b1;
                    state_next = C_IDLE;
                end
            default:
                state_next = C_IDLE;
        endcase
    end

    // result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // an accepted item always goes on to start the divider
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == C_START)
        else $error("accepted item did not start the divider");

    // divider finishes only while a run is awaited
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == C_DIV || state_reg == C_PKT_RUN ||
                          state_reg == C_SNS_RUN))
        else $error("divider finished outside a run");

    // an update presents a result and frees the input side
    a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (out_valid_reg && state_reg == C_IDLE))
        else $error("update did not produce a result");

endmodule

// File: sv/csma_cd_station_transmit_control_unit.sv
// top level of the csma/cd station transmit control unit
// Each input item is one tick of a csma/cd station: it may queue an arriving packet (up to
// QUEUE_DEPTH stamped arrivals) and advances the idle/sensing/transmitting/jamming/waiting/
// deferred controller, giving one result item per tick. An item is accepted and latched, then
// passes a setup state that starts the bit-serial divider, which scales the backoff slots by
// the link speed, a state that waits for the quotient and an update state before its result
// is presented. After a write of link_speed or packet_length the next item is held off while
// the same divider recomputes the packet and sense tick counts. A finished result waits in
// an output register while the next item is accepted; the update of that next item waits
// until the earlier result has been taken.
module csma_cd_station_transmit_control_unit #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int MAX_ATTEMPTS = 10,
    parameter int TICK_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [csma_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  csma_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output csma_pkg::out_item_t           out_data
);

    csma_pkg::ctl_cmd_t cmd;
    csma_pkg::ctl_sts_t sts;

    // sequencer
    csma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    csma_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_ATTEMPTS (MAX_ATTEMPTS),
        .TICK_WIDTH   (TICK_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule
